// ===== sv/stc_pkg.sv =====
// package for the sorted table range counter
// holds default sizes, operation codes and the controller/datapath interface structs
// no dependencies
package stc_pkg;

  // default table size and value width
  localparam int unsigned DEFAULT_TABLE_DEPTH = 1024;
  localparam int unsigned DEFAULT_VALUE_WIDTH = 16;

  // operation codes carried on the input tuser
  localparam int unsigned OP_WIDTH = 2;
  typedef logic [OP_WIDTH-1:0] op_t;
  localparam op_t OP_CLEAR  = 2'd0;
  localparam op_t OP_APPEND = 2'd1;
  localparam op_t OP_QUERY  = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;   // take the input transaction
    logic probe;    // read both search lanes at their midpoints
    logic update;   // narrow both search windows
    logic finish;   // load the output register
  } stc_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    op_t  op;           // operation of the offered transaction
    logic search_done;  // both search windows are empty
    logic out_free;     // output register can take a result
  } stc_status_t;

endpackage

// ===== sv/stc_ctrl.sv =====
// controller state machine for the sorted table range counter
// sequences accept, the paired binary search and result hand-off
// depends on stc_pkg
module stc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  stc_pkg::stc_status_t status_i,
  output stc_pkg::stc_cmd_t    cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_PROBE  = 2'd1;
  localparam logic [1:0] S_UPDATE = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (status_i.op == stc_pkg::OP_QUERY) begin
            state_d = S_PROBE;
          end else begin
            state_d = S_FINISH;
          end
        end
      end
      S_PROBE: begin
        if (status_i.search_done) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.probe = 1'b1;
          state_d     = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = S_PROBE;
      end
      S_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/stc_datapath.sv =====
// datapath for the sorted table range counter
// table memory, entry count, two search lanes and the output register
// depends on stc_pkg
module stc_datapath #(
  parameter int unsigned TABLE_DEPTH = stc_pkg::DEFAULT_TABLE_DEPTH,
  parameter int unsigned VALUE_WIDTH = stc_pkg::DEFAULT_VALUE_WIDTH,
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  stc_pkg::op_t                  op_i,
  input  logic signed [VALUE_WIDTH-1:0] entry_value_i,
  input  logic signed [VALUE_WIDTH-1:0] range_low_i,
  input  logic signed [VALUE_WIDTH-1:0] range_high_i,
  input  stc_pkg::stc_cmd_t             cmd_i,
  output stc_pkg::stc_status_t          status_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [CW-1:0]                 in_range_count_o,
  output logic                          status_flag_o
);

  logic signed [VALUE_WIDTH-1:0] table_mem [TABLE_DEPTH];

  logic [CW-1:0]                 count_q;
  logic [CW-1:0]                 lo_l_q, hi_l_q, lo_u_q, hi_u_q;
  logic [CW-1:0]                 mid_l, mid_u;
  logic signed [VALUE_WIDTH-1:0] key_l_q, key_u_q;
  logic signed [VALUE_WIDTH-1:0] rd_l_q, rd_u_q;
  logic                          drop_q;
  logic                          full;
  logic                          done_l, done_u;
  logic                          left_l, left_u;
  logic                          out_valid_q;
  logic [CW-1:0]                 out_count_q;
  logic                          out_status_q;
  logic                          is_clear, is_append, is_query;

  assign is_clear  = (op_i == stc_pkg::OP_CLEAR);
  assign is_append = (op_i == stc_pkg::OP_APPEND);
  assign is_query  = (op_i == stc_pkg::OP_QUERY);
  assign full      = (count_q == CW'(TABLE_DEPTH));

  // search midpoints
  assign mid_l  = lo_l_q + ((hi_l_q - lo_l_q) >> 1);
  assign mid_u  = lo_u_q + ((hi_u_q - lo_u_q) >> 1);
  assign done_l = (lo_l_q >= hi_l_q);
  assign done_u = (lo_u_q >= hi_u_q);

  // lower bound goes left on key <= entry, upper bound on key < entry
  assign left_l = (key_l_q <= rd_l_q);
  assign left_u = (key_u_q < rd_u_q);

  // table write port
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && is_append && !full) begin
      table_mem[count_q[AW-1:0]] <= entry_value_i;
    end
  end

  // two registered read ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.probe) begin
      rd_l_q <= table_mem[mid_l[AW-1:0]];
      rd_u_q <= table_mem[mid_u[AW-1:0]];
    end
  end

  // keys and drop flag of the current transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      key_l_q <= range_low_i;
      key_u_q <= range_high_i;
      drop_q  <= is_append && full;
    end
  end

  // entry count and search windows
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      lo_l_q  <= '0;
      hi_l_q  <= '0;
      lo_u_q  <= '0;
      hi_u_q  <= '0;
    end else if (cmd_i.accept) begin
      if (is_clear) begin
        count_q <= '0;
      end else if (is_append && !full) begin
        count_q <= count_q + CW'(1);
      end
      lo_l_q <= '0;
      lo_u_q <= '0;
      hi_l_q <= is_query ? count_q : '0;
      hi_u_q <= is_query ? count_q : '0;
    end else if (cmd_i.update) begin
      if (!done_l) begin
        if (left_l) begin
          hi_l_q <= mid_l;
        end else begin
          lo_l_q <= mid_l + CW'(1);
        end
      end
      if (!done_u) begin
        if (left_u) begin
          hi_u_q <= mid_u;
        end else begin
          lo_u_q <= mid_u + CW'(1);
        end
      end
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload, difference clamped at zero
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_count_q  <= (lo_u_q > lo_l_q) ? (lo_u_q - lo_l_q) : '0;
      out_status_q <= drop_q;
    end
  end

  assign status_o.op          = op_i;
  assign status_o.search_done = done_l && done_u;
  assign status_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign in_range_count_o = out_count_q;
  assign status_flag_o    = out_status_q;

  // entry count stays within the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  // search windows never invert
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lo_l_q <= hi_l_q) && (lo_u_q <= hi_u_q))
    else $error("search window inverted");

  // a probe is only issued while a lane is still open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.probe |-> !(done_l && done_u))
    else $error("probe after search finished");

  // a result never overwrites one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten while stalled");

  // a dropped append reports no count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q) |-> (out_count_q == '0))
    else $error("dropped append carries a count");

endmodule

// ===== sv/sorted_table_range_count_core.sv =====
// top level of the sorted table range counter
// joins the controller and the datapath to the stream ports
// depends on stc_pkg, stc_ctrl, stc_datapath
//
// usage: one input transaction per item on the s_axis side, one result per item
// on the m_axis side. s_axis_tuser carries the operation: clear the table,
// append a value, or count entries in the inclusive range [range_low,
// range_high]. values must be appended in ascending order. an append to a full
// table is dropped and reported with m_axis_tuser set.
// clear and append go from accept straight to the finish state, which loads the
// output register. a query runs the lower-bound and upper-bound binary searches
// side by side on two read ports of the table memory; each probe is a registered
// read, then a window update, repeated until both windows are empty, and the
// finish state then loads the result into the output register.
// one item is in work at a time; s_axis_tready rises once the previous
// result is loaded into the output register, so a new item can start while
// that result still waits. if the receiver stalls, the result holds and the
// next item stops before its own result.
// reset: the entry count clears to zero, no result is pending; the table
// memory needs no clearing since only filled entries are read.
module sorted_table_range_count_core #(
  parameter int unsigned TABLE_DEPTH = stc_pkg::DEFAULT_TABLE_DEPTH,
  parameter int unsigned VALUE_WIDTH = stc_pkg::DEFAULT_VALUE_WIDTH,
  localparam int unsigned CW  = $clog2(TABLE_DEPTH + 1),
  localparam int unsigned IDW = ((3 * VALUE_WIDTH + 7) / 8) * 8,
  localparam int unsigned ODW = ((CW + 7) / 8) * 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // entry_value, range_low, range_high (lowest bits first)
  input  logic [IDW-1:0]       s_axis_tdata,
  // op
  input  stc_pkg::op_t         s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // in_range_count
  output logic [ODW-1:0]       m_axis_tdata,
  // status
  output logic                 m_axis_tuser
);

  stc_pkg::stc_cmd_t    cmd;
  stc_pkg::stc_status_t status;
  logic [CW-1:0]        count;

  // state machine
  stc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // table, search lanes and output register
  stc_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .op_i             (s_axis_tuser),
    .entry_value_i    (s_axis_tdata[VALUE_WIDTH-1:0]),
    .range_low_i      (s_axis_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH]),
    .range_high_i     (s_axis_tdata[3*VALUE_WIDTH-1:2*VALUE_WIDTH]),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .in_range_count_o (count),
    .status_flag_o    (m_axis_tuser)
  );

  assign m_axis_tdata = ODW'(count);

endmodule

// ===== test/tb_top.sv =====
// testbench for the sorted table range counter: directed table, then random load/query traffic
// keeps its own copy of the table and the binary searches to predict every result
// depends on stc_pkg and sorted_table_range_count_core
module tb_top;

  localparam int TBL_DEPTH   = stc_pkg::DEFAULT_TABLE_DEPTH;
  localparam int VAL_MIN     = -32768;
  localparam int VAL_MAX     = 32767;
  localparam int ITEM_TARGET = 1800;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_WAIT  = 40;
  localparam int REPORT_MAX  = 10;
  localparam stc_pkg::op_t OP_UNUSED = 2'd3;

  // one result as the block should deliver it
  typedef struct packed {
    logic [15:0] count_word;
    logic        status;
  } tally_t;

  // one directed row: fields, and a fixed expectation where one is given
  typedef struct packed {
    stc_pkg::op_t op;
    logic [15:0]  ev;
    logic [15:0]  lo;
    logic [15:0]  hi;
    logic         has_exp;
    logic [10:0]  cnt;
    logic         st;
  } stim_row_t;

  localparam int NUM_ROWS = 24;
  localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{stc_pkg::OP_QUERY,  16'h0000, 16'h8000, 16'h7fff, 1'b1, 11'd0, 1'b0},  // empty table
    '{stc_pkg::OP_APPEND, 16'h8000, 16'h0000, 16'h0000, 1'b1, 11'd0, 1'b0},
    '{stc_pkg::OP_APPEND, 16'hfffb, 16'h0000, 16'h0000, 1'b0, 11'd0, 1'b0},
    '{stc_pkg::OP_APPEND, 16'hfffb, 16'h0000, 16'h0000, 1'b0, 11'd0, 1'b0},  // duplicate
    '{stc_pkg::OP_APPEND, 16'h0000, 16'h0000, 16'h0000, 1'b0, 11'd0, 1'b0},
    '{stc_pkg::OP_APPEND, 16'd100,  16'h0000, 16'h0000, 1'b0, 11'd0, 1'b0},
    '{stc_pkg::OP_APPEND, 16'h7fff, 16'h0000, 16'h0000, 1'b1, 11'd0, 1'b0},
    '{stc_pkg::OP_QUERY,  16'h0000, 16'h8000, 16'h7fff, 1'b1, 11'd6, 1'b0},  // whole range
    '{stc_pkg::OP_QUERY,  16'h0000, 16'hfffb, 16'hfffb, 1'b0, 11'd0, 1'b0},
    '{stc_pkg::OP_QUERY,  16'h0000, 16'd1,    16'd99,   1'b0, 11'd0, 1'b0},
    '{stc_pkg::OP_QUERY,  16'h0000, 16'd100,  16'hfffb, 1'b1, 11'd0, 1'b0},  // low above high
    '{stc_pkg::OP_QUERY,  16'h0000, 16'h7fff, 16'h7fff, 1'b0, 11'd0, 1'b0},
    '{stc_pkg::OP_QUERY,  16'h0000, 16'h8000, 16'h8000, 1'b0, 11'd0, 1'b0},
    '{OP_UNUSED,          16'hffff, 16'hffff, 16'hffff, 1'b1, 11'd0, 1'b0},
    '{stc_pkg::OP_APPEND, 16'd10,   16'h0000, 16'h0000, 1'b0, 11'd0, 1'b0},  // out of order
    '{stc_pkg::OP_QUERY,  16'h0000, 16'h0000, 16'd200,  1'b0, 11'd0, 1'b0},
    '{stc_pkg::OP_CLEAR,  16'hffff, 16'hffff, 16'hffff, 1'b1, 11'd0, 1'b0},
    '{stc_pkg::OP_QUERY,  16'h0000, 16'h8000, 16'h7fff, 1'b1, 11'd0, 1'b0},  // after clear
    '{stc_pkg::OP_APPEND, 16'haaaa, 16'h5555, 16'haaaa, 1'b1, 11'd0, 1'b0},
    '{stc_pkg::OP_APPEND, 16'h5555, 16'haaaa, 16'h5555, 1'b1, 11'd0, 1'b0},
    '{stc_pkg::OP_QUERY,  16'h0000, 16'haaaa, 16'h5555, 1'b1, 11'd2, 1'b0},
    '{stc_pkg::OP_QUERY,  16'h5555, 16'h5555, 16'haaaa, 1'b1, 11'd0, 1'b0},
    '{OP_UNUSED,          16'h0000, 16'h0000, 16'h0000, 1'b1, 11'd0, 1'b0},
    '{stc_pkg::OP_CLEAR,  16'h0000, 16'h0000, 16'h0000, 1'b1, 11'd0, 1'b0}
  };

  logic         clk_i;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [47:0]  s_axis_tdata  = '0;   // entry_value, range_low, range_high
  stc_pkg::op_t s_axis_tuser  = stc_pkg::OP_CLEAR;  // op
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [15:0]  m_axis_tdata;         // in_range_count
  logic         m_axis_tuser;         // status

  // predictor state
  logic signed [15:0] entry_vals [TBL_DEPTH];
  int                 fill_level = 0;
  int                 run_top    = VAL_MIN;
  tally_t             pending_tallies [$];

  int items_sent   = 0;
  int err_cnt      = 0;
  int stall_cycles = 0;
  bit idle_on      = 1'b1;
  bit hold_req     = 1'b0;

  sorted_table_range_count_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // first index whose entry is >= key, or > key when strict
  function automatic int bound_index(logic signed [15:0] key, bit strict);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = fill_level;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (strict ? (key < entry_vals[mid]) : (key <= entry_vals[mid])) hi = mid;
      else lo = mid + 1;
    end
    return lo;
  endfunction

  // apply one transaction to the table copy and return its result
  function automatic tally_t predict_tally(stc_pkg::op_t op, logic signed [15:0] ev,
                                           logic signed [15:0] lo, logic signed [15:0] hi);
    tally_t t;
    int     first;
    int     past;
    t = '0;
    case (op)
      stc_pkg::OP_CLEAR: begin
        fill_level = 0;
      end
      stc_pkg::OP_APPEND: begin
        if (fill_level >= TBL_DEPTH) begin
          t.status = 1'b1;
        end else begin
          entry_vals[fill_level] = ev;
          fill_level++;
        end
      end
      stc_pkg::OP_QUERY: begin
        if (fill_level > 0) begin
          first = bound_index(lo, 1'b0);
          past  = bound_index(hi, 1'b1);
          if (past > first) t.count_word = 16'(past - first);
        end
      end
      default: ;
    endcase
    return t;
  endfunction

  function automatic logic [15:0] rnd_word();
    return 16'($urandom);
  endfunction

  // offer one transaction, wait for the handshake, then record its expectation
  task automatic send_item(input stc_pkg::op_t op, input logic [15:0] ev,
                           input logic [15:0] lo, input logic [15:0] hi,
                           input logic has_exp, input logic [10:0] exp_cnt,
                           input logic exp_st);
    tally_t t;
    while (idle_on && $urandom_range(0, 99) < 38) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {hi, lo, ev};
    do @(posedge clk_i); while (!s_axis_tready);
    t = predict_tally(op, ev, lo, hi);
    if (has_exp) t = '{count_word: {5'd0, exp_cnt}, status: exp_st};
    pending_tallies.push_back(t);
    items_sent++;
  endtask

  // ascending run of appends, continuing from the last value loaded
  task automatic append_run(input int n, input int max_step);
    int step;
    for (int i = 0; i < n; i++) begin
      step = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, max_step));
      run_top = (run_top + step > VAL_MAX) ? VAL_MAX : run_top + step;
      send_item(stc_pkg::OP_APPEND, 16'(run_top), rnd_word(), rnd_word(), 1'b0, 11'd0, 1'b0);
    end
  endtask

  // bound near a stored entry half of the time, else an extreme or anything
  function automatic logic [15:0] pick_bound();
    int v;
    case ($urandom_range(0, 5))
      0: v = VAL_MIN;
      1: v = VAL_MAX;
      2, 3, 4: begin
        if (fill_level > 0) begin
          v = entry_vals[$urandom_range(0, fill_level - 1)];
          v = v + int'($urandom_range(0, 2)) - 1;
          if (v < VAL_MIN) v = VAL_MIN;
          if (v > VAL_MAX) v = VAL_MAX;
        end else begin
          v = int'($signed(rnd_word()));
        end
      end
      default: v = int'($signed(rnd_word()));
    endcase
    return 16'(v);
  endfunction

  task automatic send_query();
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] tmp;
    lo = pick_bound();
    hi = pick_bound();
    // mostly ordered ranges, a few left with low above high
    if ($signed(lo) > $signed(hi) && $urandom_range(0, 3) != 0) begin
      tmp = lo;
      lo  = hi;
      hi  = tmp;
    end
    send_item(stc_pkg::OP_QUERY, rnd_word(), lo, hi, 1'b0, 11'd0, 1'b0);
  endtask

  // clear now and then, load a short sorted run, query it, with some noise
  task automatic run_sequence();
    int n_q;
    if (fill_level > 900 || $urandom_range(0, 3) == 0) begin
      send_item(stc_pkg::OP_CLEAR, rnd_word(), rnd_word(), rnd_word(), 1'b0, 11'd0, 1'b0);
      run_top = VAL_MIN + int'($urandom_range(0, 60000));
    end
    append_run($urandom_range(0, 20), 3000);
    n_q = $urandom_range(1, 6);
    repeat (n_q) send_query();
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 2))
        0: send_item(OP_UNUSED, rnd_word(), rnd_word(), rnd_word(), 1'b0, 11'd0, 1'b0);
        1: send_item(stc_pkg::OP_APPEND, rnd_word(), rnd_word(), rnd_word(),
                     1'b0, 11'd0, 1'b0);
        default: send_item(stc_pkg::OP_QUERY, rnd_word(), rnd_word(), rnd_word(),
                           1'b0, 11'd0, 1'b0);
      endcase
    end
  endtask

  // fill the whole table, push past full, then query the full table
  task automatic fill_to_full();
    send_item(stc_pkg::OP_CLEAR, rnd_word(), rnd_word(), rnd_word(), 1'b0, 11'd0, 1'b0);
    run_top = VAL_MIN;
    append_run(TBL_DEPTH, 63);
    repeat (3) send_item(stc_pkg::OP_APPEND, rnd_word(), rnd_word(), rnd_word(),
                         1'b1, 11'd0, 1'b1);
    send_item(stc_pkg::OP_QUERY, rnd_word(), 16'h8000, 16'h7fff, 1'b1, 11'd1024, 1'b0);
    repeat (30) send_query();
  endtask

  task automatic note_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= REPORT_MAX) $display("mismatch: %s", msg);
  endtask

  // result checker
  always @(posedge clk_i) begin
    tally_t exp_t;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_tallies.size() == 0) begin
        note_mismatch($sformatf("unexpected result count=%0d status=%0d",
                                m_axis_tdata, m_axis_tuser));
      end else begin
        exp_t = pending_tallies.pop_front();
        if (m_axis_tdata !== exp_t.count_word)
          note_mismatch($sformatf("count expected %0d got %0d",
                                  exp_t.count_word, m_axis_tdata));
        if (m_axis_tuser !== exp_t.status)
          note_mismatch($sformatf("status expected %0d got %0d",
                                  exp_t.status, m_axis_tuser));
      end
    end
  end

  // result side ready, with random stalls and one long hold-off
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      m_axis_tready <= !(idle_on && $urandom_range(0, 99) < 38);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // main stimulus
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NUM_ROWS; r++) begin
      send_item(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].ev, DIRECTED_ROWS[r].lo,
                DIRECTED_ROWS[r].hi, DIRECTED_ROWS[r].has_exp, DIRECTED_ROWS[r].cnt,
                DIRECTED_ROWS[r].st);
    end

    while (items_sent < 350) run_sequence();
    // back-to-back stretch, no idling on either side
    idle_on = 1'b0;
    while (items_sent < 560) run_sequence();
    // long receiver hold-off while the sender keeps offering
    hold_req = 1'b1;
    while (items_sent < 620) run_sequence();
    idle_on = 1'b1;
    fill_to_full();
    while (items_sent < ITEM_TARGET) run_sequence();
    s_axis_tvalid <= 1'b0;

    while (pending_tallies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
